FILE: rtl/vn_pkg.sv
// Package for the vector normalizer: shared widths and the pipeline payload type.
// No dependencies; used by vn_sqrt, vn_div and vector3_normalize.
package vn_pkg;
    localparam int unsigned CompW = 32;
    localparam int unsigned SumW  = 64;
    localparam int unsigned RootW = 32;
    localparam int unsigned DivW  = 63;  // dividend |c| << 30 needs 62 bits, one spare
    localparam int unsigned QuoW  = 32;

    typedef struct packed {
        logic [CompW-1:0] mag_x;
        logic [CompW-1:0] mag_y;
        logic [CompW-1:0] mag_z;
        logic [2:0]       neg;
    } t_comp;
endpackage

FILE: rtl/vn_sqrt.sv
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// Depends on vn_pkg; carries a sideband payload alongside each operand.
module vn_sqrt #(
    parameter int unsigned SideW = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [vn_pkg::SumW-1:0]   i_radicand,
    input  logic [SideW-1:0]          i_side,
    output logic                      o_valid,
    output logic [vn_pkg::RootW-1:0]  o_root,
    output logic [SideW-1:0]          o_side
);
    import vn_pkg::*;

    localparam int unsigned NStg = RootW;

    logic [NStg:0]            r_vld;
    logic [SumW-1:0]          r_rem  [NStg+1];
    logic [RootW-1:0]         r_root [NStg+1];
    logic [SideW-1:0]         r_side [NStg+1];

    always_comb begin
        r_vld[0]  = i_valid;
        r_rem[0]  = i_radicand;
        r_root[0] = '0;
        r_side[0] = i_side;
    end

    // Stage k decides result bit B = RootW-1-k. The partial root holds its bits in
    // place, so setting bit B grows the square by (root << (B+1)) + (1 << 2B).
    for (genvar k = 0; k < NStg; k++) begin : g_stg
        localparam int unsigned B = NStg - 1 - k;
        logic [SumW+1:0] trial;
        logic [SumW-1:0] n_rem;
        logic [RootW-1:0] n_root;
        always_comb begin
            trial = ({2'b0, r_rem[k]}) -
                    (((SumW+2)'(r_root[k]) << (B + 1)) | ((SumW+2)'(1) << (2*B)));
            if (!trial[SumW+1]) begin
                n_rem  = trial[SumW-1:0];
                n_root = r_root[k] | (RootW'(1) << B);
            end else begin
                n_rem  = r_rem[k];
                n_root = r_root[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1]  <= n_rem;
            r_root[k+1] <= n_root;
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_vld[NStg];
    assign o_root  = r_root[NStg];
    assign o_side  = r_side[NStg];
endmodule

FILE: rtl/vn_div.sv
// Pipelined restoring divider: 63-bit dividend over 32-bit divisor, one quotient bit a stage.
// Depends on vn_pkg; the quotient is known to fit in QuoW bits.
module vn_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [vn_pkg::DivW-1:0]  i_dividend,
    input  logic [vn_pkg::RootW-1:0] i_divisor,
    output logic [vn_pkg::QuoW-1:0]  o_quot
);
    import vn_pkg::*;

    // The quotient is below 2^31, so bits above that are known zero; still we run
    // QuoW steps starting with the remainder holding the top DivW-QuoW bits.
    localparam int unsigned NStg = QuoW;
    localparam int unsigned RemW = RootW + 1;

    logic [NStg:0]        r_vld;
    logic [RemW-1:0]      r_rem [NStg+1];
    logic [QuoW-1:0]      r_dvd [NStg+1];
    logic [RootW-1:0]     r_dsr [NStg+1];

    always_comb begin
        r_vld[0] = i_valid;
        r_rem[0] = RemW'(i_dividend[DivW-1:QuoW]);
        r_dvd[0] = i_dividend[QuoW-1:0];
        r_dsr[0] = i_divisor;
    end

    for (genvar k = 0; k < NStg; k++) begin : g_stg
        logic [RemW:0]   shifted;
        logic [RemW:0]   diff;
        logic [RemW-1:0] n_rem;
        logic [QuoW-1:0] n_dvd;
        always_comb begin
            shifted = {r_rem[k], r_dvd[k][QuoW-1]};
            diff    = shifted - {2'b0, r_dsr[k]};
            n_dvd   = {r_dvd[k][QuoW-2:0], ~diff[RemW]};
            n_rem   = diff[RemW] ? shifted[RemW-1:0] : diff[RemW-1:0];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            if (r_vld[k]) begin
                r_rem[k+1] <= n_rem;
                r_dvd[k+1] <= n_dvd;
                r_dsr[k+1] <= r_dsr[k];
            end
        end
    end

    assign o_quot = r_dvd[NStg];
endmodule

FILE: rtl/vector3_normalize.sv
// Top level of the 3D vector normalizer: squares, square root, three dividers.
// Depends on vn_pkg, vn_sqrt and vn_div.
//
// The block takes one vector (x, y, z) in signed Q16.16 on every clock cycle in
// which start is high; busy is tied low, so a transfer is never refused. Each
// vector comes out as one result, marked by o_done for a single cycle, in input
// order, after the absolute-value register, the squares register, 32 root stages,
// 32 divider stages and the output register. The depth comes from the bit-serial
// pipelines: one stage per bit of the 32-bit square root and one per quotient
// bit of the dividers. Throughput is one vector per clock. The receiver cannot
// hold results off, so it must take o_done whenever it appears. The magnitude is
// floor(sqrt(x*x+y*y+z*z)) in unsigned Q16.16; the unit components are
// component/magnitude in signed Q2.30, truncated toward zero. A zero vector gives
// zero components, magnitude zero and o_zero_length set.
module vector3_normalize (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_x_in,
    input  logic [31:0] i_y_in,
    input  logic [31:0] i_z_in,
    output logic        o_done,
    output logic [31:0] o_x_unit,
    output logic [31:0] o_y_unit,
    output logic [31:0] o_z_unit,
    output logic [31:0] o_magnitude,
    output logic        o_zero_length
);
    import vn_pkg::*;

    localparam int unsigned CompSz = $bits(t_comp);
    localparam int unsigned DivLat = QuoW;

    assign busy = 1'b0;

    // Stage 1: absolute values and signs.
    logic  r_v1;
    t_comp r_c1;
    t_comp n_c1;

    always_comb begin
        n_c1.neg   = {i_z_in[CompW-1], i_y_in[CompW-1], i_x_in[CompW-1]};
        n_c1.mag_x = i_x_in[CompW-1] ? (~i_x_in + 1'b1) : i_x_in;
        n_c1.mag_y = i_y_in[CompW-1] ? (~i_y_in + 1'b1) : i_y_in;
        n_c1.mag_z = i_z_in[CompW-1] ? (~i_z_in + 1'b1) : i_z_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_c1 <= n_c1;
    end

    // Stage 2: three 32x32 squares, registered before they are summed.
    logic            r_v2;
    t_comp           r_c2;
    logic [SumW-1:0] r_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_c2    <= r_c1;
        r_sq[0] <= SumW'(r_c1.mag_x) * SumW'(r_c1.mag_x);
        r_sq[1] <= SumW'(r_c1.mag_y) * SumW'(r_c1.mag_y);
        r_sq[2] <= SumW'(r_c1.mag_z) * SumW'(r_c1.mag_z);
    end

    // The sum of three squares of at most 2^62 stays below 2^64.
    logic [SumW-1:0] sum_sq;
    assign sum_sq = r_sq[0] + r_sq[1] + r_sq[2];

    logic              sq_vld;
    logic [RootW-1:0]  sq_root;
    logic [CompSz-1:0] sq_side;
    t_comp             c3;

    vn_sqrt #(.SideW(CompSz)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v2),
        .i_radicand (sum_sq),
        .i_side     (r_c2),
        .o_valid    (sq_vld),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    assign c3 = t_comp'(sq_side);

    // A zero root would make the dividers meaningless; divide by one instead,
    // the output stage forces the zero result.
    logic [RootW-1:0] divisor;
    assign divisor = (sq_root == '0) ? RootW'(1) : sq_root;

    logic [QuoW-1:0] quot [3];
    logic [CompW-1:0] mags [3];
    assign mags[0] = c3.mag_x;
    assign mags[1] = c3.mag_y;
    assign mags[2] = c3.mag_z;

    for (genvar i = 0; i < 3; i++) begin : g_div
        vn_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (sq_vld),
            .i_dividend ({1'b0, mags[i], 30'b0}),
            .i_divisor  (divisor),
            .o_quot     (quot[i])
        );
    end

    // Sideband line that runs beside the dividers: valid, signs, root.
    logic [DivLat:0]  r_dv;
    logic [2:0]       r_dneg  [DivLat+1];
    logic [RootW-1:0] r_droot [DivLat+1];

    always_comb begin
        r_dv[0]    = sq_vld;
        r_dneg[0]  = c3.neg;
        r_droot[0] = sq_root;
    end

    for (genvar k = 0; k < DivLat; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else begin
                r_dv[k+1] <= r_dv[k];
            end
            r_dneg[k+1]  <= r_dneg[k];
            r_droot[k+1] <= r_droot[k];
        end
    end

    // Output register: apply signs and the zero-length case.
    logic            zl;
    logic [QuoW-1:0] n_unit [3];
    assign zl = (r_droot[DivLat] == '0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (zl) begin
                n_unit[i] = '0;
            end else if (r_dneg[DivLat][i]) begin
                n_unit[i] = ~quot[i] + 1'b1;
            end else begin
                n_unit[i] = quot[i];
            end
        end
    end

    logic             r_done;
    logic [QuoW-1:0]  r_unit [3];
    logic [RootW-1:0] r_mag;
    logic             r_zl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv[DivLat];
        end
        r_unit[0] <= n_unit[0];
        r_unit[1] <= n_unit[1];
        r_unit[2] <= n_unit[2];
        r_mag     <= r_droot[DivLat];
        r_zl      <= zl;
    end

    assign o_done        = r_done;
    assign o_x_unit      = r_unit[0];
    assign o_y_unit      = r_unit[1];
    assign o_z_unit      = r_unit[2];
    assign o_magnitude   = r_mag;
    assign o_zero_length = r_zl;
endmodule

FILE: rtl/vn_checker.sv
// Port-level checker for the vector normalizer, bound to the top level.
// Depends on vector3_normalize ports only.
module vn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [31:0] o_x_unit,
    input logic [31:0] o_y_unit,
    input logic [31:0] o_z_unit,
    input logic [31:0] o_magnitude,
    input logic        o_zero_length
);
    // A zero-length result carries zero components and zero magnitude.
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_zero_length) |->
        (o_x_unit == '0 && o_y_unit == '0 && o_z_unit == '0 && o_magnitude == '0))
        else $error("zero-length result with nonzero fields");

    // The flag is set exactly when the magnitude is zero.
    a_flag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_zero_length == (o_magnitude == '0)))
        else $error("zero_length flag disagrees with magnitude");

    // The x unit component never exceeds one in magnitude (2^30 in Q2.30).
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($signed(o_x_unit) <= 32'sd1073741824 &&
                    $signed(o_x_unit) >= -32'sd1073741824))
        else $error("x unit out of range");

    // The block never refuses a transfer.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");
endmodule

bind vector3_normalize vn_checker u_vn_checker (.*);
